// ===== rtl/pcr_pkg.sv =====
`timescale 1ns / 1ps
package pcr_pkg;

    localparam int VEC_W     = 63;
    localparam int NRM_W     = 48;
    localparam int NRM_C     = 16;
    localparam int IM_W      = 24;
    localparam int TOT_W     = IM_W + 1;
    localparam int RATIO_W   = 17;
    localparam int PEN_W     = 21;
    localparam int REST_W    = 16;
    localparam int TS_W      = 16;
    localparam int DIV_LAT   = RATIO_W;
    localparam int FRONT_LAT = 5;
    localparam int APPLY_LAT = 3;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic            REG_TIME_STEP = 1'b0;
    localparam logic [TS_W-1:0] TIME_STEP_RST = 16'd1092;

    typedef struct packed {
        logic [VEC_W-1:0]  vel_a;
        logic [VEC_W-1:0]  vel_b;
        logic [VEC_W-1:0]  acc_a;
        logic [VEC_W-1:0]  acc_b;
        logic [VEC_W-1:0]  pos_a;
        logic [VEC_W-1:0]  pos_b;
        logic [NRM_W-1:0]  normal_vec;
        logic [IM_W-1:0]   inv_mass_a;
        logic [IM_W-1:0]   inv_mass_b;
        logic [PEN_W-1:0]  penetration;
        logic [REST_W-1:0] restitution;
        logic              has_b;
    } pcr_item_t;

    typedef struct packed {
        logic [VEC_W-1:0] new_vel_a;
        logic [VEC_W-1:0] new_vel_b;
        logic [VEC_W-1:0] new_pos_a;
        logic [VEC_W-1:0] new_pos_b;
        logic             velocity_changed;
        logic             position_changed;
    } pcr_result_t;

    typedef struct packed {
        logic vchg;
        logic pchg;
        logic has_b;
    } pcr_ctl_t;

endpackage

// ===== rtl/pcr_div.sv =====
`timescale 1ns / 1ps
module pcr_div
    import pcr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [IM_W-1:0]    num,
    input  logic [TOT_W-1:0]   den,
    output logic               out_valid,
    output logic [RATIO_W-1:0] quo
);

    logic [TOT_W-1:0]   rem_reg [DIV_LAT];
    logic [TOT_W-1:0]   den_reg [DIV_LAT];
    logic [RATIO_W-1:0] quo_reg [DIV_LAT];
    logic [DIV_LAT-1:0] v_reg;

    for (genvar k = 0; k < DIV_LAT; k++)
    begin : g_stage
        logic [TOT_W-1:0]   rem_in;
        logic [TOT_W-1:0]   den_in;
        logic [RATIO_W-1:0] quo_in;
        logic               v_in;
        logic               bit_in;
        logic [TOT_W:0]     shf;
        logic [TOT_W:0]     diff;
        logic               ge;
        logic [TOT_W-1:0]   rem_next;

        if (k == 0)
        begin : g_first
            assign rem_in = {{(TOT_W-IM_W+1){1'b0}}, num[IM_W-1:1]};
            assign bit_in = num[0];
            assign den_in = den;
            assign quo_in = '0;
            assign v_in   = in_valid;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign bit_in = 1'b0;
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign v_in   = v_reg[k-1];
        end

        assign shf      = {rem_in, bit_in};
        assign diff     = shf - {1'b0, den_in};
        assign ge       = shf >= {1'b0, den_in};
        assign rem_next = ge ? diff[TOT_W-1:0] : shf[TOT_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            den_reg[k] <= den_in;
            quo_reg[k] <= {quo_in[RATIO_W-2:0], ge};
        end
    end

    assign out_valid = v_reg[DIV_LAT-1];
    assign quo       = quo_reg[DIV_LAT-1];

endmodule

// ===== rtl/pcr_front.sv =====
`timescale 1ns / 1ps
module pcr_front
    import pcr_pkg::*;
#(
    parameter int W = 21
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [VEC_W-1:0]    vel_a,
    input  logic [VEC_W-1:0]    vel_b,
    input  logic [VEC_W-1:0]    acc_a,
    input  logic [VEC_W-1:0]    acc_b,
    input  logic [NRM_W-1:0]    normal_vec,
    input  logic [REST_W-1:0]   restitution,
    input  logic                has_b,
    input  logic [TS_W-1:0]     time_step,
    output logic                out_valid,
    output logic signed [W+23:0] dvel,
    output logic                closing
);

    localparam int PW = W + 17;
    localparam int SW = W + 19;
    localparam int NW = W + 20;
    localparam int AW = W + 36;
    localparam int MW = W + 37;
    localparam int XW = W + 20;
    localparam int TW = W + 22;
    localparam int DW = W + 24;

    logic [FRONT_LAT-1:0]   v_reg;
    logic signed [PW-1:0]   sp_reg [3];
    logic signed [PW-1:0]   ap_reg [3];
    logic [REST_W-1:0]      rest1_reg, rest2_reg, rest3_reg;
    logic signed [SW-1:0]   sep2_reg, sep3_reg, sep4_reg;
    logic signed [SW-1:0]   accd2_reg;
    logic signed [TW-1:0]   tgt3_reg, tgt4_reg;
    logic signed [AW-1:0]   acc3_reg;
    logic signed [MW-1:0]   racc4_reg;
    logic                   accneg4_reg;
    logic signed [DW-1:0]   d5_reg;
    logic                   closing5_reg;

    logic signed [NW-1:0]   neg;
    logic signed [MW-1:0]   tprod;
    logic signed [AW-1:0]   aprod;
    logic signed [XW-1:0]   accsep;
    logic signed [MW-1:0]   racc;
    logic signed [TW-1:0]   corr;
    logic signed [W+22:0]   tsum;
    logic signed [W+22:0]   tclip;
    logic signed [DW-1:0]   d_next;

    for (genvar i = 0; i < 3; i++)
    begin : g_comp
        logic signed [W-1:0]     va_c, vb_c, aa_c, ab_c;
        logic signed [NRM_C-1:0] n_c;
        logic signed [W:0]       dv, da;

        assign va_c = $signed(vel_a[i*W +: W]);
        assign vb_c = has_b ? $signed(vel_b[i*W +: W]) : '0;
        assign aa_c = $signed(acc_a[i*W +: W]);
        assign ab_c = has_b ? $signed(acc_b[i*W +: W]) : '0;
        assign n_c  = $signed(normal_vec[i*NRM_C +: NRM_C]);
        assign dv   = (W+1)'(va_c) - (W+1)'(vb_c);
        assign da   = (W+1)'(aa_c) - (W+1)'(ab_c);

        always_ff @(posedge clk)
        begin
            sp_reg[i] <= PW'(dv) * PW'(n_c);
            ap_reg[i] <= PW'(da) * PW'(n_c);
        end
    end

    assign neg    = -(NW'(sep2_reg));
    assign tprod  = MW'(neg) * MW'($signed({1'b0, rest2_reg}));
    assign aprod  = AW'(accd2_reg) * AW'($signed({1'b0, time_step}));
    assign accsep = XW'(acc3_reg >>> 16);
    assign racc   = MW'(accsep) * MW'($signed({1'b0, rest3_reg}));
    assign corr   = TW'(racc4_reg >>> 15);
    assign tsum   = (W+23)'(tgt4_reg) + (accneg4_reg ? (W+23)'(corr) : '0);
    assign tclip  = tsum[W+22] ? '0 : tsum;
    assign d_next = DW'(tclip) - DW'(sep4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[FRONT_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        rest1_reg    <= restitution;
        sep2_reg     <= SW'(sp_reg[0]) + SW'(sp_reg[1]) + SW'(sp_reg[2]);
        accd2_reg    <= SW'(ap_reg[0]) + SW'(ap_reg[1]) + SW'(ap_reg[2]);
        rest2_reg    <= rest1_reg;
        tgt3_reg     <= TW'(tprod >>> 15);
        acc3_reg     <= aprod;
        sep3_reg     <= sep2_reg;
        rest3_reg    <= rest2_reg;
        racc4_reg    <= racc;
        accneg4_reg  <= accsep[XW-1];
        tgt4_reg     <= tgt3_reg;
        sep4_reg     <= sep3_reg;
        d5_reg       <= d_next;
        closing5_reg <= sep4_reg[SW-1] || (sep4_reg == '0);
    end

    assign out_valid = v_reg[FRONT_LAT-1];
    assign dvel      = d5_reg;
    assign closing   = closing5_reg;

endmodule

// ===== rtl/pcr_apply.sv =====
`timescale 1ns / 1ps
module pcr_apply
    import pcr_pkg::*;
#(
    parameter int W = 21
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  pcr_ctl_t             ctl,
    input  logic signed [W+23:0] dvel,
    input  logic [RATIO_W-1:0]   ra,
    input  logic [RATIO_W-1:0]   rb,
    input  logic [VEC_W-1:0]     vel_a,
    input  logic [VEC_W-1:0]     vel_b,
    input  logic [VEC_W-1:0]     pos_a,
    input  logic [VEC_W-1:0]     pos_b,
    input  logic [NRM_W-1:0]     normal_vec,
    input  logic [PEN_W-1:0]     penetration,
    output logic                 done,
    output pcr_result_t          result
);

    localparam int DW   = W + 24;
    localparam int MULW = DW + RATIO_W + 1;
    localparam int TAW  = W + 26;
    localparam int MVW  = W + 43;
    localparam int PRW  = PEN_W + RATIO_W + 1;
    localparam int PMW  = PRW + NRM_C + 1;
    localparam int CW   = W + 14;

    localparam logic signed [CW-1:0] SAT_HI = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [CW-1:0] SAT_LO = {{(CW-W+1){1'b1}}, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sat(input logic signed [CW-1:0] x);
        logic signed [CW-1:0] y;
        begin
            y = x;
            if (x > SAT_HI)
                y = SAT_HI;
            else if (x < SAT_LO)
                y = SAT_LO;
            sat = y[W-1:0];
        end
    endfunction

    logic [1:0]             v_reg;
    pcr_ctl_t               ctl1_reg, ctl2_reg;
    logic signed [TAW-1:0]  ta_reg, tb_reg;
    logic signed [PRW-1:0]  pra_reg, prb_reg;
    logic [VEC_W-1:0]       va1_reg, vb1_reg, pa1_reg, pb1_reg;
    logic [VEC_W-1:0]       va2_reg, vb2_reg, pa2_reg, pb2_reg;
    logic [NRM_W-1:0]       n1_reg;
    logic signed [MVW-1:0]  mva_reg [3];
    logic signed [MVW-1:0]  mvb_reg [3];
    logic signed [PMW-1:0]  mpa_reg [3];
    logic signed [PMW-1:0]  mpb_reg [3];
    pcr_result_t            result_reg;
    logic                   done_reg;

    logic signed [MULW-1:0] mul_a, mul_b;
    logic signed [PRW-1:0]  pra_next, prb_next;
    logic [3*W-1:0]         nva, nvb, npa, npb;
    pcr_result_t            result_next;

    assign mul_a    = MULW'(dvel) * MULW'($signed({1'b0, ra}));
    assign mul_b    = MULW'(dvel) * MULW'($signed({1'b0, rb}));
    assign pra_next = PRW'($signed(penetration)) * PRW'($signed({1'b0, ra}));
    assign prb_next = PRW'($signed(penetration)) * PRW'($signed({1'b0, rb}));

    for (genvar i = 0; i < 3; i++)
    begin : g_comp
        logic signed [NRM_C-1:0] n_c;
        logic signed [CW-1:0]    dva, dvb, dpa, dpb;
        logic signed [CW-1:0]    sva, svb, spa, spb;

        assign n_c = $signed(n1_reg[i*NRM_C +: NRM_C]);

        always_ff @(posedge clk)
        begin
            mva_reg[i] <= MVW'(ta_reg) * MVW'(n_c);
            mvb_reg[i] <= -(MVW'(tb_reg) * MVW'(n_c));
            mpa_reg[i] <= PMW'(pra_reg) * PMW'(n_c);
            mpb_reg[i] <= -(PMW'(prb_reg) * PMW'(n_c));
        end

        assign dva = ctl2_reg.vchg ? CW'(mva_reg[i] >>> 30) : '0;
        assign dvb = (ctl2_reg.vchg && ctl2_reg.has_b) ? CW'(mvb_reg[i] >>> 30) : '0;
        assign dpa = ctl2_reg.pchg ? CW'(mpa_reg[i] >>> 31) : '0;
        assign dpb = (ctl2_reg.pchg && ctl2_reg.has_b) ? CW'(mpb_reg[i] >>> 31) : '0;

        assign sva = CW'($signed(va2_reg[i*W +: W])) + dva;
        assign svb = CW'($signed(vb2_reg[i*W +: W])) + dvb;
        assign spa = CW'($signed(pa2_reg[i*W +: W])) + dpa;
        assign spb = CW'($signed(pb2_reg[i*W +: W])) + dpb;

        assign nva[i*W +: W] = sat(sva);
        assign nvb[i*W +: W] = sat(svb);
        assign npa[i*W +: W] = sat(spa);
        assign npb[i*W +: W] = sat(spb);
    end

    always_comb
    begin
        result_next.new_vel_a        = VEC_W'(nva);
        result_next.new_vel_b        = VEC_W'(nvb);
        result_next.new_pos_a        = VEC_W'(npa);
        result_next.new_pos_b        = VEC_W'(npb);
        result_next.velocity_changed = ctl2_reg.vchg;
        result_next.position_changed = ctl2_reg.pchg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= {v_reg[0], in_valid};
            done_reg <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        ta_reg     <= TAW'(mul_a >>> 16);
        tb_reg     <= TAW'(mul_b >>> 16);
        pra_reg    <= pra_next;
        prb_reg    <= prb_next;
        ctl1_reg   <= ctl;
        va1_reg    <= vel_a;
        vb1_reg    <= vel_b;
        pa1_reg    <= pos_a;
        pb1_reg    <= pos_b;
        n1_reg     <= normal_vec;
        ctl2_reg   <= ctl1_reg;
        va2_reg    <= va1_reg;
        vb2_reg    <= vb1_reg;
        pa2_reg    <= pa1_reg;
        pb2_reg    <= pb1_reg;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/particle_contact_resolver_unit.sv =====
`timescale 1ns / 1ps
// Particle contact resolver, fully pipelined.
// Input channel: drive item and pulse start; a beat is taken at every edge with
// start high and busy low. busy is always low, so a contact can enter every cycle.
// Result channel: done is high for exactly one cycle with the beat on result;
// the receiver must take it then, there is no back-pressure.
// The 17-stage restoring divider that forms the two inverse-mass shares (one
// quotient bit per stage) is followed by three multiply/apply stages.
// Throughput: one contact per cycle.
// Configuration: APB register time_step at byte address 0 (unsigned Q0.16),
// written only while no contact is in flight; the user must keep to this,
// the block does not enforce it. pready is always high.
// Reset: rst_n clears all valid bits and done, and loads time_step with 1092;
// contacts in flight are dropped.
module particle_contact_resolver_unit
    import pcr_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 21
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pcr_item_t         item,
    output logic              done,
    output pcr_result_t       result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int W     = COMPONENT_WIDTH;
    localparam int DW    = W + 24;
    localparam int GAP   = DIV_LAT - FRONT_LAT;
    localparam int LAT   = DIV_LAT + APPLY_LAT;

    typedef struct packed {
        logic [VEC_W-1:0] vel_a;
        logic [VEC_W-1:0] vel_b;
        logic [VEC_W-1:0] pos_a;
        logic [VEC_W-1:0] pos_b;
        logic [NRM_W-1:0] normal_vec;
        logic [PEN_W-1:0] penetration;
        logic             has_b;
        logic             tot_pos;
    } pcr_carry_t;

    logic [TS_W-1:0]      time_step_reg;
    pcr_carry_t           carry_reg [DIV_LAT];
    logic signed [DW-1:0] dly_d_reg [GAP];
    logic                 dly_c_reg [GAP];

    logic [TOT_W-1:0]     total;
    logic [IM_W-1:0]      imb;
    pcr_carry_t           carry_in;
    logic                 front_valid;
    logic signed [DW-1:0] front_d;
    logic                 front_closing;
    logic                 div_a_valid, div_b_valid;
    logic [RATIO_W-1:0]   ra, rb;
    pcr_carry_t           carry_out;
    pcr_ctl_t             ctl;
    logic                 pen_pos;
    logic                 wr_en;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_TIME_STEP);
    assign prdata = (paddr[ADDR_W-1:2] == REG_TIME_STEP) ? DATA_W'(time_step_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_step_reg <= TIME_STEP_RST;
        else if (wr_en)
            time_step_reg <= pwdata[TS_W-1:0];
    end

    assign imb   = item.has_b ? item.inv_mass_b : '0;
    assign total = TOT_W'(item.inv_mass_a) + TOT_W'(imb);

    always_comb
    begin
        carry_in.vel_a       = item.vel_a;
        carry_in.vel_b       = item.vel_b;
        carry_in.pos_a       = item.pos_a;
        carry_in.pos_b       = item.pos_b;
        carry_in.normal_vec  = item.normal_vec;
        carry_in.penetration = item.penetration;
        carry_in.has_b       = item.has_b;
        carry_in.tot_pos     = (total != '0);
    end

    pcr_div u_div_a
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .num       (item.inv_mass_a),
        .den       (total),
        .out_valid (div_a_valid),
        .quo       (ra)
    );

    pcr_div u_div_b
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .num       (imb),
        .den       (total),
        .out_valid (div_b_valid),
        .quo       (rb)
    );

    pcr_front #(.W(W)) u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .vel_a       (item.vel_a),
        .vel_b       (item.vel_b),
        .acc_a       (item.acc_a),
        .acc_b       (item.acc_b),
        .normal_vec  (item.normal_vec),
        .restitution (item.restitution),
        .has_b       (item.has_b),
        .time_step   (time_step_reg),
        .out_valid   (front_valid),
        .dvel        (front_d),
        .closing     (front_closing)
    );

    always_ff @(posedge clk)
    begin
        carry_reg[0] <= carry_in;
        for (int k = 1; k < DIV_LAT; k++)
            carry_reg[k] <= carry_reg[k-1];
        dly_d_reg[0] <= front_d;
        dly_c_reg[0] <= front_closing;
        for (int k = 1; k < GAP; k++)
        begin
            dly_d_reg[k] <= dly_d_reg[k-1];
            dly_c_reg[k] <= dly_c_reg[k-1];
        end
    end

    assign carry_out = carry_reg[DIV_LAT-1];
    assign pen_pos   = !carry_out.penetration[PEN_W-1] && (carry_out.penetration != '0);

    always_comb
    begin
        ctl.vchg  = dly_c_reg[GAP-1] && carry_out.tot_pos;
        ctl.pchg  = pen_pos && carry_out.tot_pos;
        ctl.has_b = carry_out.has_b;
    end

    pcr_apply #(.W(W)) u_apply
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (div_a_valid),
        .ctl         (ctl),
        .dvel        (dly_d_reg[GAP-1]),
        .ra          (ra),
        .rb          (rb),
        .vel_a       (carry_out.vel_a),
        .vel_b       (carry_out.vel_b),
        .pos_a       (carry_out.pos_a),
        .pos_b       (carry_out.pos_b),
        .normal_vec  (carry_out.normal_vec),
        .penetration (carry_out.penetration),
        .done        (done),
        .result      (result)
    );

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("contact beat did not complete on time");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result beat without a matching contact");

    a_front_align: assert property (@(posedge clk) disable iff (!rst_n)
        front_valid |-> (div_b_valid == div_a_valid) && $past(start, FRONT_LAT))
        else $error("front pipeline out of step with input");

    a_share_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (div_a_valid && carry_out.tot_pos) |->
            ((RATIO_W+1)'(ra) + (RATIO_W+1)'(rb)) <= (RATIO_W+1)'(1 << 16))
        else $error("inverse-mass shares exceed unity");
`endif

endmodule
